/* hw/rtl/tcs_pkg.sv */
// Shared types, constants and arithmetic helpers for the tile color shading block.
`timescale 1ns / 1ps

package tcs_pkg;

  localparam int NSTAGE = 6;

  localparam int FL_BLOCK    = 0;
  localparam int FL_NONEMPTY = 1;
  localparam int FL_BORDER   = 2;
  localparam int FL_HOUSE    = 3;
  localparam int FL_PZ       = 4;
  localparam int FL_PVP      = 5;
  localparam int FL_NOLOGOUT = 6;
  localparam int FL_NOPVP    = 7;

  localparam int MD_BLOCK   = 0;
  localparam int MD_ITEMS   = 1;
  localparam int MD_SPAWNS  = 2;
  localparam int MD_HOUSES  = 3;
  localparam int MD_SPECIAL = 4;

  localparam logic [7:0]  TWO_THIRDS = 8'd171;
  localparam logic [31:0] HASH_MUL   = 32'h045d9f3b;
  localparam logic [7:0]  DARK_FLOOR = 8'd50;
  localparam logic [7:0]  DARK_LIFT  = 8'd100;
  localparam logic [7:0]  PULSE_GAIN = 8'd154;

  typedef enum logic [1:0] {
    CFG_MODES = 2'd0,
    CFG_HOUSE = 2'd1,
    CFG_PULSE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0] flags;
    logic       sel;
    logic       tinted;
  } tile_ctl_t;

  typedef struct packed {
    logic [4:0]  modes;
    logic [31:0] house;
    logic [15:0] gain;
  } cfg_t;

  function automatic logic [7:0] scale8(logic [7:0] c, logic [7:0] f);
    logic [15:0] p;
    p = 16'(c) * 16'(f);
    return p[15:8];
  endfunction

  function automatic logic [31:0] mix32(logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 16);
    return y * HASH_MUL;
  endfunction

  function automatic logic [7:0] item_factor(logic [7:0] n);
    logic [7:0] f;
    case (n)
      8'd1:    f = 8'd192;
      8'd2:    f = 8'd154;
      8'd3:    f = 8'd123;
      8'd4:    f = 8'd102;
      default: f = 8'd84;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] spawn_scale(logic [7:0] n);
    logic [7:0] f;
    case (n)
      8'd1:    f = 8'd179;
      8'd2:    f = 8'd125;
      8'd3:    f = 8'd88;
      8'd4:    f = 8'd61;
      8'd5:    f = 8'd43;
      8'd6:    f = 8'd30;
      8'd7:    f = 8'd21;
      8'd8:    f = 8'd15;
      default: f = 8'd10;
    endcase
    return f;
  endfunction

endpackage

/* hw/rtl/tcs_cfg.sv */
// Configuration registers with the precomputed pulse gain.
`timescale 1ns / 1ps

module tcs_cfg import tcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODES: cfg_nxt.modes = cfg_wdata[4:0];
        CFG_HOUSE: cfg_nxt.house = cfg_wdata;
        CFG_PULSE: cfg_nxt.gain  = 16'(cfg_wdata[7:0]) * 16'(PULSE_GAIN);
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/tcs_hash.sv */
// Three-stage house id hash pipeline producing the tint color.
`timescale 1ns / 1ps

module tcs_hash import tcs_pkg::*; (
  input  logic        clk,
  input  logic [2:0]  en,
  input  logic [31:0] id_in,
  output rgb_t        tint_out
);

  logic [31:0] m1_r, m1_nxt;
  logic [31:0] m2_r, m2_nxt;
  rgb_t        tint_r, tint_nxt;
  logic [31:0] h;

  assign m1_nxt = mix32(id_in);
  assign m2_nxt = mix32(m1_r);

  always_comb begin
    h = m2_r ^ (m2_r >> 16);
    tint_nxt.r = h[7:0];
    tint_nxt.g = h[15:8];
    tint_nxt.b = h[23:16];
    if (h[7:0] < DARK_FLOOR && h[15:8] < DARK_FLOOR && h[23:16] < DARK_FLOOR) begin
      tint_nxt.r = h[7:0] + DARK_LIFT;
      tint_nxt.g = h[15:8] + DARK_LIFT;
      tint_nxt.b = h[23:16] + DARK_LIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) m1_r <= m1_nxt;
    if (en[1]) m2_r <= m2_nxt;
    if (en[2]) tint_r <= tint_nxt;
  end

  assign tint_out = tint_r;

endmodule

/* hw/rtl/tcs_front.sv */
// Blocking, item highlight and spawn darkening stages.
`timescale 1ns / 1ps

module tcs_front import tcs_pkg::*; (
  input  logic       clk,
  input  logic [2:0] en,
  input  cfg_t       cfg,
  input  rgb_t       pix_in,
  input  tile_ctl_t  ctl_in,
  input  logic [7:0] items_in,
  input  logic [7:0] spawns_in,
  output rgb_t       pix_out,
  output tile_ctl_t  ctl_out
);

  rgb_t       s1_pix_r, s1_pix_nxt;
  tile_ctl_t  s1_ctl_r;
  logic [7:0] s1_items_r;
  logic [7:0] s1_spawns_r;
  rgb_t       s2_pix_r, s2_pix_nxt;
  tile_ctl_t  s2_ctl_r;
  logic [7:0] s2_spawns_r;
  rgb_t       s3_pix_r, s3_pix_nxt;
  tile_ctl_t  s3_ctl_r;
  logic [7:0] item_f;
  logic [7:0] spawn_f;

  always_comb begin
    s1_pix_nxt = pix_in;
    if (cfg.modes[MD_BLOCK] && ctl_in.flags[FL_BLOCK] && ctl_in.flags[FL_NONEMPTY]) begin
      s1_pix_nxt.g = scale8(pix_in.g, TWO_THIRDS);
      s1_pix_nxt.b = scale8(pix_in.b, TWO_THIRDS);
    end
  end

  always_comb begin
    item_f = item_factor(s1_items_r);
    s2_pix_nxt = s1_pix_r;
    if (cfg.modes[MD_ITEMS] && s1_items_r != 8'd0 && !s1_ctl_r.flags[FL_BORDER]) begin
      s2_pix_nxt.r = scale8(s1_pix_r.r, item_f);
      s2_pix_nxt.g = scale8(s1_pix_r.g, item_f);
    end
  end

  always_comb begin
    spawn_f = spawn_scale(s2_spawns_r);
    s3_pix_nxt = s2_pix_r;
    if (cfg.modes[MD_SPAWNS] && s2_spawns_r != 8'd0) begin
      s3_pix_nxt.g = scale8(s2_pix_r.g, spawn_f);
      s3_pix_nxt.b = scale8(s2_pix_r.b, spawn_f);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_pix_r    <= s1_pix_nxt;
      s1_ctl_r    <= ctl_in;
      s1_items_r  <= items_in;
      s1_spawns_r <= spawns_in;
    end
    if (en[1]) begin
      s2_pix_r    <= s2_pix_nxt;
      s2_ctl_r    <= s1_ctl_r;
      s2_spawns_r <= s1_spawns_r;
    end
    if (en[2]) begin
      s3_pix_r <= s3_pix_nxt;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  assign pix_out = s3_pix_r;
  assign ctl_out = s3_ctl_r;

endmodule

/* hw/rtl/tcs_house.sv */
// House tint, selected house pulse and protection zone stages.
`timescale 1ns / 1ps

module tcs_house import tcs_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  cfg_t       cfg,
  input  rgb_t       pix_in,
  input  tile_ctl_t  ctl_in,
  input  rgb_t       tint_in,
  output rgb_t       pix_out,
  output tile_ctl_t  ctl_out
);

  rgb_t      s4_pix_r, s4_pix_nxt;
  tile_ctl_t s4_ctl_r, s4_ctl_nxt;
  rgb_t      s5_pix_r, s5_pix_nxt;
  tile_ctl_t s5_ctl_r;

  function automatic logic [7:0] tint8(logic [7:0] c, logic [7:0] h);
    logic [16:0] p;
    p = 17'(c) * (17'(h) + 17'd1);
    return p[15:8];
  endfunction

  function automatic logic [7:0] brighten(logic [7:0] c, logic [15:0] gain);
    logic [7:0]  d;
    logic [23:0] p;
    logic [8:0]  s;
    d = 8'd255 - c;
    p = 24'(d) * 24'(gain);
    s = 9'(c) + 9'(p[23:16]);
    return s[8] ? 8'd255 : s[7:0];
  endfunction

  always_comb begin
    s4_pix_nxt = pix_in;
    s4_ctl_nxt = ctl_in;
    s4_ctl_nxt.tinted = cfg.modes[MD_HOUSES] && ctl_in.flags[FL_HOUSE];
    if (s4_ctl_nxt.tinted) begin
      s4_pix_nxt.r = tint8(pix_in.r, tint_in.r);
      s4_pix_nxt.g = tint8(pix_in.g, tint_in.g);
      s4_pix_nxt.b = tint8(pix_in.b, tint_in.b);
    end
  end

  always_comb begin
    s5_pix_nxt = s4_pix_r;
    if (s4_ctl_r.tinted) begin
      if (s4_ctl_r.sel) begin
        s5_pix_nxt.r = brighten(s4_pix_r.r, cfg.gain);
        s5_pix_nxt.g = brighten(s4_pix_r.g, cfg.gain);
        s5_pix_nxt.b = brighten(s4_pix_r.b, cfg.gain);
      end
    end else if (cfg.modes[MD_SPECIAL] && s4_ctl_r.flags[FL_PZ]) begin
      s5_pix_nxt.r = s4_pix_r.r >> 1;
      s5_pix_nxt.b = s4_pix_r.b >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4_pix_r <= s4_pix_nxt;
      s4_ctl_r <= s4_ctl_nxt;
    end
    if (en[1]) begin
      s5_pix_r <= s5_pix_nxt;
      s5_ctl_r <= s4_ctl_r;
    end
  end

  assign pix_out = s5_pix_r;
  assign ctl_out = s5_ctl_r;

endmodule

/* hw/rtl/tile_color_shading_top.sv */
// Top level of the tile color shading pipeline.
`timescale 1ns / 1ps

// Shades one tile color per request through a six-stage pipeline: blocking, item
// highlight and spawn darkening, then house tint, selected house pulse or
// protection zone, then the pvp, no-logout and no-pvp marks. A request is taken
// in every cycle unless the input stage is full and held by a stall further down;
// the house id hash, whose two 32-bit multiplies and final fold take three stages,
// runs beside the three front stages ahead of the tint multiply. Each stage holds its
// own valid bit, so a stalled result only stops the stages behind it that are full.

module tile_color_shading_top import tcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_tile_flags,
  input  logic [7:0]  in_item_total,
  input  logic [7:0]  in_spawn_total,
  input  logic [31:0] in_house_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t              cfg;
  logic [NSTAGE-1:0] en;
  logic [NSTAGE-1:0] stage_v_r, stage_v_nxt;
  rgb_t              pix_in, front_pix, house_pix, tint;
  tile_ctl_t         ctl_in, front_ctl, house_ctl;
  rgb_t              out_pix_r, out_pix_nxt;

  tcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  always_comb begin
    en[NSTAGE-1] = !stage_v_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !stage_v_r[k] || en[k+1];
    end
  end

  always_comb begin
    stage_v_nxt[0] = en[0] ? in_valid : stage_v_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      stage_v_nxt[k] = en[k] ? stage_v_r[k-1] : stage_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= '0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  assign in_ready = en[0];

  always_comb begin
    pix_in.r = in_red_in;
    pix_in.g = in_green_in;
    pix_in.b = in_blue_in;
    ctl_in.flags  = in_tile_flags;
    ctl_in.sel    = (in_house_number == cfg.house);
    ctl_in.tinted = 1'b0;
  end

  tcs_hash u_hash (
    .clk      (clk),
    .en       (en[2:0]),
    .id_in    (in_house_number),
    .tint_out (tint)
  );

  tcs_front u_front (
    .clk       (clk),
    .en        (en[2:0]),
    .cfg       (cfg),
    .pix_in    (pix_in),
    .ctl_in    (ctl_in),
    .items_in  (in_item_total),
    .spawns_in (in_spawn_total),
    .pix_out   (front_pix),
    .ctl_out   (front_ctl)
  );

  tcs_house u_house (
    .clk     (clk),
    .en      (en[4:3]),
    .cfg     (cfg),
    .pix_in  (front_pix),
    .ctl_in  (front_ctl),
    .tint_in (tint),
    .pix_out (house_pix),
    .ctl_out (house_ctl)
  );

  always_comb begin
    out_pix_nxt = house_pix;
    if (cfg.modes[MD_SPECIAL]) begin
      if (house_ctl.flags[FL_PVP]) begin
        out_pix_nxt.g = out_pix_nxt.r >> 2;
        out_pix_nxt.b = scale8(out_pix_nxt.b, TWO_THIRDS);
      end
      if (house_ctl.flags[FL_NOLOGOUT]) begin
        out_pix_nxt.b = out_pix_nxt.b >> 1;
      end
      if (house_ctl.flags[FL_NOPVP]) begin
        out_pix_nxt.g = out_pix_nxt.g >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTAGE-1]) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_valid     = stage_v_r[NSTAGE-1];
  assign out_red_out   = out_pix_r.r;
  assign out_green_out = out_pix_r.g;
  assign out_blue_out  = out_pix_r.b;

  a_empty_entry_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stage_v_r[0] |-> in_ready)
    else $error("Input stage is empty but the pipeline refuses a request.");

  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("Output is being taken but the pipeline still stalls its input.");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> stage_v_r == '0)
    else $error("Pipeline holds a valid stage right after reset.");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    stage_v_r[2] && !en[2] |=> stage_v_r[2])
    else $error("A stalled middle stage dropped its request.");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the tile color shading pipeline with a scoreboard class.
`timescale 1ns / 1ps

module testbench;
  import tcs_pkg::*;

  localparam int LATENCY     = 6;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 148;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  flags;
    logic [7:0]  items;
    logic [7:0]  spawns;
    logic [31:0] house;
  } tile_t;

  class shade_board;
    logic [4:0]  modes;
    logic [31:0] sel_house;
    logic [7:0]  pulse;
    rgb_t        pixel_q[$];
    int          errors;
    int          seen;
    int          checked;
    int unsigned item_gain[5]  = '{192, 154, 123, 102, 84};
    int unsigned spawn_gain[9] = '{179, 125, 88, 61, 43, 30, 21, 15, 10};

    function new();
      modes = '0;
      sel_house = '0;
      pulse = '0;
      errors = 0;
      seen = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_MODES: modes = val[4:0];
        CFG_HOUSE: sel_house = val;
        CFG_PULSE: pulse = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned fold_mul(int unsigned x);
      int unsigned y;
      y = x ^ (x >> 16);
      return y * HASH_MUL;
    endfunction

    function int unsigned tint_hash(int unsigned id);
      int unsigned h;
      h = fold_mul(fold_mul(id));
      return h ^ (h >> 16);
    endfunction

    function int unsigned pulse_up(int unsigned c);
      int unsigned v;
      v = c + (((255 - c) * pulse * PULSE_GAIN) >> 16);
      return (v > 255) ? 255 : v;
    endfunction

    function rgb_t shade(tile_t t);
      int unsigned r, g, b, f, h, hr, hg, hb;
      int idx;
      bit special;
      rgb_t o;
      r = t.r;
      g = t.g;
      b = t.b;
      special = modes[MD_SPECIAL];
      if (modes[MD_BLOCK] && t.flags[FL_BLOCK] && t.flags[FL_NONEMPTY]) begin
        g = (g * TWO_THIRDS) >> 8;
        b = (b * TWO_THIRDS) >> 8;
      end
      if (modes[MD_ITEMS] && t.items != 0 && !t.flags[FL_BORDER]) begin
        idx = (t.items > 5) ? 4 : int'(t.items) - 1;
        f = item_gain[idx];
        g = (g * f) >> 8;
        r = (r * f) >> 8;
      end
      if (modes[MD_SPAWNS] && t.spawns != 0) begin
        idx = (t.spawns > 9) ? 8 : int'(t.spawns) - 1;
        f = spawn_gain[idx];
        g = (g * f) >> 8;
        b = (b * f) >> 8;
      end
      if (modes[MD_HOUSES] && t.flags[FL_HOUSE]) begin
        h = tint_hash(t.house);
        hr = h & 255;
        hg = (h >> 8) & 255;
        hb = (h >> 16) & 255;
        if (hr < DARK_FLOOR && hg < DARK_FLOOR && hb < DARK_FLOOR) begin
          hr += DARK_LIFT;
          hg += DARK_LIFT;
          hb += DARK_LIFT;
        end
        r = (r * (hr + 1)) >> 8;
        g = (g * (hg + 1)) >> 8;
        b = (b * (hb + 1)) >> 8;
        if (t.house == sel_house && pulse != 0) begin
          r = pulse_up(r);
          g = pulse_up(g);
          b = pulse_up(b);
        end
      end else if (special && t.flags[FL_PZ]) begin
        r = r >> 1;
        b = b >> 1;
      end
      if (special && t.flags[FL_PVP]) begin
        g = r >> 2;
        b = (b * TWO_THIRDS) >> 8;
      end
      if (special && t.flags[FL_NOLOGOUT]) b = b >> 1;
      if (special && t.flags[FL_NOPVP]) g = g >> 1;
      o.r = 8'(r);
      o.g = 8'(g);
      o.b = 8'(b);
      return o;
    endfunction

    function void note_tile(tile_t t);
      pixel_q.push_back(shade(t));
      seen++;
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t want;
      string chan[3] = '{"blue", "green", "red"};
      if (pixel_q.size() == 0) begin
        $display("%0t: pixel %h arrived with none expected", $time, got);
        errors++;
        return;
      end
      want = pixel_q.pop_front();
      checked++;
      for (int k = 0; k < 3; k++) begin
        if (want[k*8 +: 8] != got[k*8 +: 8]) begin
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, chan[k],
                   want[k*8 +: 8], got[k*8 +: 8]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_red_in;
  logic [7:0]  in_green_in;
  logic [7:0]  in_blue_in;
  logic [7:0]  in_tile_flags;
  logic [7:0]  in_item_total;
  logic [7:0]  in_spawn_total;
  logic [31:0] in_house_number;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  shade_board  board = new();
  bit          calm;
  bit          hold_req;
  logic [31:0] dark_house;
  int          settings;

  tile_color_shading_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_tile_flags  (in_tile_flags),
    .in_item_total  (in_item_total),
    .in_spawn_total (in_spawn_total),
    .in_house_number(in_house_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic tile_t mk_tile(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                    logic [7:0] fl, logic [7:0] it, logic [7:0] sp,
                                    logic [31:0] hs);
    tile_t t;
    t = '{r: r, g: g, b: b, flags: fl, items: it, spawns: sp, house: hs};
    return t;
  endfunction

  function automatic logic [7:0] rand_count(int top);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, top));
  endfunction

  function automatic tile_t rand_tile();
    tile_t t;
    t.r = 8'($urandom);
    t.g = 8'($urandom);
    t.b = 8'($urandom);
    t.flags = 8'($urandom);
    t.items = rand_count(7);
    t.spawns = rand_count(11);
    case ($urandom_range(0, 7))
      0, 1, 2: t.house = board.sel_house;
      3:       t.house = dark_house;
      4:       t.house = 32'h0;
      5:       t.house = 32'hffff_ffff;
      default: t.house = $urandom;
    endcase
    return t;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    board.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_tile(tile_t t);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red_in <= t.r;
    in_green_in <= t.g;
    in_blue_in <= t.b;
    in_tile_flags <= t.flags;
    in_item_total <= t.items;
    in_spawn_total <= t.spawns;
    in_house_number <= t.house;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_all(logic [4:0] m, logic [31:0] hs, logic [7:0] p);
    write_reg(CFG_MODES, 32'(m));
    write_reg(CFG_HOUSE, hs);
    write_reg(CFG_PULSE, 32'(p));
    write_reg(CFG_SPARE, $urandom);
    settings++;
  endtask

  // The receiver stalls at random unless calm; on request it holds off for a long stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        board.note_tile(mk_tile(in_red_in, in_green_in, in_blue_in, in_tile_flags,
                                in_item_total, in_spawn_total, in_house_number));
      if (out_valid && out_ready)
        board.check_pixel('{r: out_red_out, g: out_green_out, b: out_blue_out});
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [4:0]  m;
    logic [31:0] hs;
    logic [7:0]  p;
    int unsigned h;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    in_tile_flags = '0;
    in_item_total = '0;
    in_spawn_total = '0;
    in_house_number = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    settings = 0;

    // Find a house id whose hash color is dark enough to get lifted.
    dark_house = 32'd1;
    h = board.tint_hash(dark_house);
    while (!((h & 255) < DARK_FLOOR && ((h >> 8) & 255) < DARK_FLOOR &&
             ((h >> 16) & 255) < DARK_FLOOR)) begin
      dark_house++;
      h = board.tint_hash(dark_house);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    set_all(5'h1f, dark_house, 8'hff);
    send_tile(mk_tile(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h03, 8'h00, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h01, 8'h00, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h00, 8'd1, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h00, 8'd5, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h00, 8'd255, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h04, 8'd255, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'd1, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'd9, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'd255, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h08, 8'h00, 8'h00, dark_house));
    send_tile(mk_tile(8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, dark_house));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h08, 8'h00, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h08, 8'h00, 8'h00, 32'hffff_ffff));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h10, 8'h00, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h18, 8'h00, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h20, 8'h00, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h40, 8'h00, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h80, 8'h00, 8'h00, 32'h0));
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'hff, 8'd255, 8'd255, dark_house));
    drain();

    // A selected house with zero pulse must get the tint alone.
    set_all(5'h1f, dark_house, 8'h00);
    send_tile(mk_tile(8'hff, 8'hff, 8'hff, 8'h08, 8'h00, 8'h00, dark_house));
    send_tile(mk_tile(8'h80, 8'h40, 8'h20, 8'hff, 8'd3, 8'd4, dark_house));
    drain();

    set_all(5'h00, 32'hffff_ffff, 8'd1);
    send_tile(mk_tile(8'hff, 8'h7f, 8'h01, 8'hff, 8'd255, 8'd255, 32'hffff_ffff));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      m = (ph == 0) ? 5'h00 : (ph == 1) ? 5'h1f : 5'($urandom_range(0, 31));
      if (ph % 2 == 1) m[MD_HOUSES] = 1'b1;
      case (ph % 4)
        0:       hs = 32'h0;
        1:       hs = 32'hffff_ffff;
        2:       hs = dark_house;
        default: hs = $urandom;
      endcase
      case (ph % 4)
        0:       p = 8'hff;
        1:       p = 8'h00;
        2:       p = 8'h01;
        default: p = 8'($urandom);
      endcase
      set_all(m, hs, p);
      calm = (ph == 3 || ph == 5);
      if (ph == 3) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_tile(rand_tile());
      drain();
    end

    $display("Shaded %0d tiles and checked %0d pixels over %0d register settings,",
             board.seen, board.checked, settings);
    $display("including a long output stall, random gaps on both sides and an idle stretch.");
    if (board.errors == 0 && board.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
